@@ rtl/ffca_pkg.sv @@
// Shared types and constants for the first-fit coalescing allocator.
// No dependencies.
package ffca_pkg;

    localparam int FIELD_W = 13;
    localparam int HDR_BYTES = 8;
    localparam int CFG_AW = 3;

    localparam logic [7:0] MIN_SPLIT_RST = 8'd16;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_MIN_SPLIT = 1'b0;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] req_size;
        logic [FIELD_W-1:0] free_addr;
    } t_in_word;

    typedef struct packed {
        logic               granted;
        logic [FIELD_W-1:0] grant_addr;
    } t_out_word;

endpackage

@@ rtl/first_fit_coalescing_allocator.sv @@
// Top level of the first-fit coalescing allocator.
// Depends on ffca_pkg, ffca_cfg, ffca_hdr_mem and ffca_walk.
//
// Hardware first-fit allocator over a byte pool of POOL_BYTES bytes. The pool
// is a chain of chunks from offset 0, each led by an 8-byte header (size, used)
// kept in a header RAM with one entry per byte offset. A request word is taken
// on a clock edge with start high and busy low. Exactly one result word comes
// back, shown for a single cycle with o_res_valid; the receiver cannot stall
// it, so it must take it in that cycle. An allocate walks the chain at one
// header per clock (the RAM read port sets that pace) up to the first free
// chunk that is large enough, or fails at the end of the chain; a split adds
// a step that writes the header of the split-off tail, and a zero size fails
// without a walk. A free clears the used mark, then one merge walk visits
// every chunk header, one per clock; an address outside the pool skips the
// clearing step. busy stays high for the whole walk. After reset a setup
// step writes the head chunk header; busy is high for it.
// min_split is written through the APB port at byte address 0; the user must
// write it only while the block is idle, as the block does not enforce it.
module first_fit_coalescing_allocator #(
    parameter int POOL_BYTES = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request / result
    input  logic                        start,
    output logic                        busy,
    input  ffca_pkg::t_in_word          i_req,
    output logic                        o_res_valid,
    output ffca_pkg::t_out_word         o_res,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffca_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(POOL_BYTES);

    logic [7:0]    min_split;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [AW:0]   rd_data, wr_data;

    ffca_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_min_split (min_split)
    );

    // header RAM: {used, size} per byte offset
    ffca_hdr_mem #(
        .DEPTH (POOL_BYTES),
        .AW    (AW),
        .DW    (AW + 1)
    ) u_hdr_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // walk sequencer: reads the next header while deciding on the current one
    ffca_walk #(
        .POOL_BYTES (POOL_BYTES)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_min_split (min_split),
        .o_busy      (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

endmodule

@@ rtl/ffca_hdr_mem.sv @@
// Chunk header store: one write port, one read port, registered read data.
// No dependencies.
module ffca_hdr_mem #(
    parameter int DEPTH = 8192,
    parameter int AW = 13,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ffca_cfg.sv @@
// APB-style register file holding min_split.
// Depends on ffca_pkg.
module ffca_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ffca_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [7:0]                 o_min_split
);

    logic [7:0] r_min_split;
    logic       wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr[2] == ffca_pkg::REG_MIN_SPLIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_split <= ffca_pkg::MIN_SPLIT_RST;
        end else if (wr_hit) begin
            r_min_split <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == ffca_pkg::REG_MIN_SPLIT) begin
            prdata = {24'd0, r_min_split};
        end
    end

    assign pready = 1'b1;
    assign o_min_split = r_min_split;

endmodule

@@ rtl/ffca_walk.sv @@
// Chain walk sequencer: first-fit search with split, free and merge pass.
// Depends on ffca_pkg; drives the ports of ffca_hdr_mem.
module ffca_walk #(
    parameter int POOL_BYTES = 8192,
    localparam int AW = $clog2(POOL_BYTES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ffca_pkg::t_in_word  i_req,
    input  logic [7:0]          i_min_split,
    output logic                o_busy,
    output logic                o_res_valid,
    output ffca_pkg::t_out_word o_res,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  logic [AW:0]         i_rd_data,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [AW:0]         o_wr_data
);

    localparam int WW = ((AW > ffca_pkg::FIELD_W) ? AW : ffca_pkg::FIELD_W) + 2;
    localparam logic [WW-1:0] CHAIN_END = WW'(POOL_BYTES);
    localparam logic [WW-1:0] HDR = WW'(ffca_pkg::HDR_BYTES);
    localparam logic [AW-1:0] INIT_SIZE = AW'(POOL_BYTES - ffca_pkg::HDR_BYTES);

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_A_CHK   = 3'd2;
    localparam logic [2:0] ST_A_SPLIT = 3'd3;
    localparam logic [2:0] ST_F_WR    = 3'd4;
    localparam logic [2:0] ST_M_START = 3'd5;
    localparam logic [2:0] ST_M_CUR   = 3'd6;
    localparam logic [2:0] ST_M_RUN   = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_cur, n_cur;
    logic [AW-1:0]       r_nxt, n_nxt;
    logic [AW-1:0]       r_acc, n_acc;
    logic [AW-1:0]       r_sp, n_sp;
    logic [AW-1:0]       r_sp_size, n_sp_size;
    ffca_pkg::t_in_word  r_req, n_req;
    logic                r_res_valid, n_res_valid;
    ffca_pkg::t_out_word r_res, n_res;

    logic          h_used;
    logic [AW-1:0] h_size;
    logic [WW-1:0] cur_w, size_w, req_w, nxt_w, rest_w, rest_net_w, sp_w, grant_w;
    logic [WW-1:0] acc2_w, nxt2_w, after_w, fa_w, fa_off_w;
    logic          fit, split, fa_ok;

    assign h_used = i_rd_data[AW];
    assign h_size = i_rd_data[AW-1:0];

    always_comb begin
        cur_w      = WW'(r_cur);
        size_w     = WW'(h_size);
        req_w      = WW'(r_req.req_size);
        nxt_w      = cur_w + HDR + size_w;
        fit        = !h_used && (size_w >= req_w);
        rest_w     = size_w - req_w;
        rest_net_w = rest_w - HDR;
        sp_w       = cur_w + HDR + req_w;
        split      = (rest_w >= HDR + WW'(i_min_split)) && (sp_w < CHAIN_END);
        grant_w    = cur_w + HDR;
        acc2_w     = WW'(r_acc) + HDR + size_w;
        nxt2_w     = cur_w + HDR + acc2_w;
        after_w    = WW'(r_nxt) + HDR + size_w;
        fa_w       = WW'(i_req.free_addr);
        fa_off_w   = fa_w - HDR;
        fa_ok      = (fa_w >= HDR) && (fa_off_w < CHAIN_END);
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_acc       = r_acc;
        n_sp        = r_sp;
        n_sp_size   = r_sp_size;
        n_req       = r_req;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_cur;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cur;
        o_wr_data   = {1'b0, h_size};

        case (r_state)
            ST_INIT: begin
                // setup of the head chunk after reset
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = {1'b0, INIT_SIZE};
                n_state   = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    if (i_req.op == ffca_pkg::OP_ALLOC) begin
                        if (i_req.req_size == '0) begin
                            n_res_valid = 1'b1;
                            n_res       = '0;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_cur     = '0;
                            n_state   = ST_A_CHK;
                        end
                    end else if (fa_ok) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = fa_off_w[AW-1:0];
                        n_cur     = fa_off_w[AW-1:0];
                        n_state   = ST_F_WR;
                    end else begin
                        n_state = ST_M_START;
                    end
                end
            end
            ST_A_CHK: begin
                if (fit) begin
                    o_wr_en = 1'b1;
                    if (split) begin
                        o_wr_data = {1'b1, req_w[AW-1:0]};
                        n_sp      = sp_w[AW-1:0];
                        n_sp_size = rest_net_w[AW-1:0];
                        n_state   = ST_A_SPLIT;
                    end else begin
                        o_wr_data   = {1'b1, h_size};
                        n_res_valid = 1'b1;
                        n_res       = '{granted: 1'b1, grant_addr: grant_w[12:0]};
                        n_state     = ST_IDLE;
                    end
                end else if (nxt_w < CHAIN_END) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = nxt_w[AW-1:0];
                    n_cur     = nxt_w[AW-1:0];
                end else begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    n_state     = ST_IDLE;
                end
            end
            ST_A_SPLIT: begin
                o_wr_en     = 1'b1;
                o_wr_addr   = r_sp;
                o_wr_data   = {1'b0, r_sp_size};
                n_res_valid = 1'b1;
                n_res       = '{granted: 1'b1, grant_addr: grant_w[12:0]};
                n_state     = ST_IDLE;
            end
            ST_F_WR: begin
                // clear used mark, keep size
                o_wr_en   = 1'b1;
                o_wr_data = {1'b0, h_size};
                n_state   = ST_M_START;
            end
            ST_M_START: begin
                o_rd_en   = 1'b1;
                o_rd_addr = '0;
                n_cur     = '0;
                n_state   = ST_M_CUR;
            end
            ST_M_CUR: begin
                if (!h_used) begin
                    n_acc = h_size;
                end
                if (nxt_w < CHAIN_END) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = nxt_w[AW-1:0];
                    if (!h_used) begin
                        n_nxt   = nxt_w[AW-1:0];
                        n_state = ST_M_RUN;
                    end else begin
                        n_cur = nxt_w[AW-1:0];
                    end
                end else begin
                    n_res_valid = 1'b1;
                    n_res       = '{granted: 1'b1, grant_addr: '0};
                    n_state     = ST_IDLE;
                end
            end
            ST_M_RUN: begin
                // r_cur is free with size r_acc; header at r_nxt just read
                if (!h_used) begin
                    n_acc = acc2_w[AW-1:0];
                    if (nxt2_w < CHAIN_END) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = nxt2_w[AW-1:0];
                        n_nxt     = nxt2_w[AW-1:0];
                    end else begin
                        o_wr_en     = 1'b1;
                        o_wr_data   = {1'b0, acc2_w[AW-1:0]};
                        n_res_valid = 1'b1;
                        n_res       = '{granted: 1'b1, grant_addr: '0};
                        n_state     = ST_IDLE;
                    end
                end else begin
                    // close the run; skip past the used chunk already in hand
                    o_wr_en   = 1'b1;
                    o_wr_data = {1'b0, r_acc};
                    if (after_w < CHAIN_END) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = after_w[AW-1:0];
                        n_cur     = after_w[AW-1:0];
                        n_state   = ST_M_CUR;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res       = '{granted: 1'b1, grant_addr: '0};
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_nxt     <= n_nxt;
        r_acc     <= n_acc;
        r_sp      <= n_sp;
        r_sp_size <= n_sp_size;
        r_req     <= n_req;
        r_res     <= n_res;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the first-fit coalescing allocator (first_fit_coalescing_allocator).
// Needs ffca_pkg and the allocator RTL. A scoreboard class mirrors the chunk chain to predict
// every result word; plain tasks drive the request and APB ports.
`timescale 1ns / 100ps

module tb;

    localparam int POOL_BYTES      = 8192;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int POST_CYCLES     = 32;
    localparam int MAX_PRINTS      = 30;
    // worst case is a merge walk over ~900 chunks per word, with margin on top
    localparam longint TIMEOUT_NS  = 64'd50_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    ffca_pkg::t_in_word   i_req;
    logic                 o_res_valid;
    ffca_pkg::t_out_word  o_res;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ffca_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // Shadow of the header store plus the queue of result words still owed.
    class alloc_scoreboard;
        int unsigned         chunk_size [POOL_BYTES];
        bit                  chunk_used [POOL_BYTES];
        int unsigned         min_split;
        ffca_pkg::t_out_word expected_q [$];
        int unsigned         errors;
        int unsigned         n_granted;
        int unsigned         n_refused;
        int unsigned         n_freed;

        function new();
            chunk_size[0] = POOL_BYTES - ffca_pkg::HDR_BYTES;
            min_split     = 32'(ffca_pkg::MIN_SPLIT_RST);
        endfunction

        // one pass over the chain, folding every run of free neighbors into its head
        function void coalesce();
            int unsigned cur;
            int unsigned nxt;
            cur = 0;
            while (cur < POOL_BYTES) begin
                nxt = cur + ffca_pkg::HDR_BYTES + chunk_size[cur];
                if (!chunk_used[cur]) begin
                    while (nxt < POOL_BYTES && !chunk_used[nxt]) begin
                        chunk_size[cur] += ffca_pkg::HDR_BYTES + chunk_size[nxt];
                        nxt = cur + ffca_pkg::HDR_BYTES + chunk_size[cur];
                    end
                end
                cur = nxt;
            end
        endfunction

        // returns usable-area offset, 0 on no fit
        function int unsigned first_fit(int unsigned want);
            int unsigned cur;
            int unsigned rest;
            int unsigned tail;
            cur = 0;
            while (cur < POOL_BYTES) begin
                if (!chunk_used[cur] && chunk_size[cur] >= want) begin
                    rest = chunk_size[cur] - want;
                    if (rest >= ffca_pkg::HDR_BYTES + min_split) begin
                        tail = cur + ffca_pkg::HDR_BYTES + want;
                        if (tail < POOL_BYTES) begin
                            chunk_size[tail] = rest - ffca_pkg::HDR_BYTES;
                            chunk_used[tail] = 1'b0;
                            chunk_size[cur]  = want;
                        end
                    end
                    chunk_used[cur] = 1'b1;
                    return cur + ffca_pkg::HDR_BYTES;
                end
                cur += ffca_pkg::HDR_BYTES + chunk_size[cur];
            end
            return 0;
        endfunction

        function ffca_pkg::t_out_word note_request(ffca_pkg::t_in_word w);
            ffca_pkg::t_out_word r;
            int unsigned         got;
            int unsigned         area;
            if (w.op == ffca_pkg::OP_ALLOC) begin
                got          = (w.req_size != 0) ? first_fit(32'(w.req_size)) : 0;
                r.granted    = (got != 0);
                r.grant_addr = got[ffca_pkg::FIELD_W-1:0];
                if (r.granted) n_granted++;
                else n_refused++;
            end else begin
                area = 32'(w.free_addr);
                // trusted address: out-of-pool offsets clear nothing
                if (area >= ffca_pkg::HDR_BYTES && area - ffca_pkg::HDR_BYTES < POOL_BYTES)
                    chunk_used[area - ffca_pkg::HDR_BYTES] = 1'b0;
                coalesce();
                r.granted    = 1'b1;
                r.grant_addr = '0;
                n_freed++;
            end
            expected_q.push_back(r);
            return r;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(ffca_pkg::t_out_word got);
            ffca_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                report_mismatch("result word with nothing pending", 32'(got), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.granted !== want.granted)
                report_mismatch("granted", 32'(got.granted), 32'(want.granted));
            if (got.grant_addr !== want.grant_addr)
                report_mismatch("grant_addr", 32'(got.grant_addr), 32'(want.grant_addr));
        endtask
    endclass

    alloc_scoreboard sb = new();

    int unsigned live_q  [$];   // addresses handed out, candidates for a free
    int unsigned freed_q [$];   // recent free addresses, reused for double frees
    int unsigned n_cfg;

    first_fit_coalescing_allocator #(
        .POOL_BYTES(POOL_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result words cannot be held off: take each one on the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            sb.check_result(o_res);
    end

    function automatic ffca_pkg::t_in_word alloc_word(int unsigned size);
        ffca_pkg::t_in_word w;
        w.op        = ffca_pkg::OP_ALLOC;
        w.req_size  = size[ffca_pkg::FIELD_W-1:0];
        w.free_addr = ffca_pkg::FIELD_W'($urandom);   // ignored on allocate
        return w;
    endfunction

    function automatic ffca_pkg::t_in_word free_word(int unsigned area);
        ffca_pkg::t_in_word w;
        w.op        = ffca_pkg::OP_FREE;
        w.req_size  = ffca_pkg::FIELD_W'($urandom);   // ignored on free
        w.free_addr = area[ffca_pkg::FIELD_W-1:0];
        return w;
    endfunction

    // Leaves start high so a following word in the same burst goes out without a gap.
    task automatic send_word(input ffca_pkg::t_in_word w);
        ffca_pkg::t_out_word pred;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy);
        pred = sb.note_request(w);
        if (w.op == ffca_pkg::OP_ALLOC && pred.granted)
            live_q.push_back(32'(pred.grant_addr));
        if (w.op == ffca_pkg::OP_FREE) begin
            freed_q.push_back(32'(w.free_addr));
            if (freed_q.size() > 32) void'(freed_q.pop_front());
        end
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles == 0) return;
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Drop start, wait for every owed word, then for the block to go quiet.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (POST_CYCLES) @(posedge i_clk);
    endtask

    // APB write of min_split followed by a read back; block must be idle.
    task automatic write_min_split(input logic [7:0] value);
        logic [31:0] rd;
        settle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ffca_pkg::REG_MIN_SPLIT, 2'b00};
        pwdata  <= {16'($urandom_range(16'hFFFF, 0)), 8'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.min_split = 32'(value);
        n_cfg++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[7:0] !== value)
            sb.report_mismatch("min_split read back", 32'(rd[7:0]), 32'(value));
    endtask

    initial begin
        logic [7:0]         split_plan [6];
        ffca_pkg::t_in_word w;
        int unsigned        sent;
        int unsigned        burst;
        int unsigned        k;
        int unsigned        idx;
        int unsigned        pick;
        int unsigned        area;
        bit                 no_idle;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        n_cfg   = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty pool, default split threshold ---
        send_word(alloc_word(0));          // zero size never fits
        send_word(alloc_word(8191));       // larger than the largest free chunk
        send_word(alloc_word(8184));       // exact fit, whole pool, no split
        send_word(alloc_word(1));          // pool full: no fit
        send_word(free_word(8));
        send_word(free_word(8));           // already free, merge still runs
        send_word(free_word(0));           // below header: nothing cleared
        send_word(free_word(5));
        send_word(free_word(8191));        // off the chain, near pool end
        send_word(alloc_word(100));
        send_word(alloc_word(1));
        send_word(alloc_word(200));
        send_word(free_word(116));         // both neighbors used, nothing merges
        send_word(free_word(60));          // interior of a chunk
        send_word(free_word(8));           // head and its free neighbor merge
        // zero threshold: leftover of exactly one header splits into a 0-byte chunk
        write_min_split(8'd0);
        send_word(alloc_word(101));
        send_word(alloc_word(1));
        send_word(free_word(8));
        // largest threshold: small leftovers are absorbed into the grant
        write_min_split(8'd255);
        send_word(alloc_word(1));
        send_word(free_word(8));
        send_word(alloc_word(4000));

        // --- random: mostly sane alloc/free traffic, some junk addresses ---
        split_plan = '{8'd16, 8'd0, 8'd255, 8'd0, 8'd8, 8'd64};
        split_plan[3] = 8'($urandom_range(254, 1));
        foreach (split_plan[p]) begin
            write_min_split(split_plan[p]);
            no_idle = (p == 4);            // one phase runs back to back
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(12, 1);
                for (k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
                    if (live_q.size() == 0 || $urandom_range(99, 0) < 55) begin
                        pick = $urandom_range(99, 0);
                        if (pick < 4)       w = alloc_word(0);
                        else if (pick < 74) w = alloc_word($urandom_range(200, 1));
                        else if (pick < 95) w = alloc_word($urandom_range(2000, 201));
                        else                w = alloc_word($urandom_range(8191, 2001));
                    end else begin
                        pick = $urandom_range(99, 0);
                        if (pick < 85) begin
                            idx  = $urandom_range(live_q.size() - 1, 0);
                            area = live_q[idx];
                            live_q.delete(idx);
                        end else if (pick < 93 && freed_q.size() != 0) begin
                            area = freed_q[$urandom_range(freed_q.size() - 1, 0)];
                        end else begin
                            area = $urandom_range(8191, 0);
                        end
                        w = free_word(area);
                    end
                    send_word(w);
                    sent++;
                end
                if (!no_idle)
                    idle_gap(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1));
            end
        end

        settle();
        if (sb.expected_q.size() != 0)
            sb.report_mismatch("result words never arrived", 32'(sb.expected_q.size()), 32'd0);

        $display("Covered %0d allocations granted, %0d refused and %0d frees",
                 sb.n_granted, sb.n_refused, sb.n_freed);
        $display("across %0d min_split settings (0 and 255 included); %0d mismatches",
                 n_cfg, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d result words still pending", sb.expected_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
